FILE: rtl/particle_drag_gravity_step_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the particle drag and gravity step block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_DRAG_GRAVITY_STEP_TOP_ASSERT_SVH
`define PARTICLE_DRAG_GRAVITY_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds a fixed number of cycles after ante.
`define PDGS_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("pdgs: delayed check failed");

// Check that cons holds in the same cycle as ante.
`define PDGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdgs: check failed");

`else

`define PDGS_ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`define PDGS_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/pdgs_pkg.sv
// ---------------------------------------------------------------------------
// Particle drag and gravity step package
// Shared constants, types, integer square root steps and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdgs_pkg;

   localparam int SqrtSteps     = 32;
   localparam int StepsPerStage = 2;
   localparam int SqrtStages    = SqrtSteps / StepsPerStage;
   // input register, square, sum, root stages, then five stages to the output
   localparam int Latency       = SqrtStages + 8;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type RegStepTime = 2'd0;
   localparam csr_index_type RegDragCoef = 2'd1;
   localparam csr_index_type RegGravity  = 2'd2;

   localparam logic [22:0]        StepTimeReset = 23'd1092;
   localparam logic [22:0]        DragCoefReset = 23'd3277;
   localparam logic signed [23:0] GravityReset  = -24'sd642253;

   localparam logic [16:0] QOne = 17'd65536;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic             expired;
      logic             last;
   } particle_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type    o;
      logic [34:0] shifted;
      logic [34:0] trial;
      shifted = {s.rem[32:0], s.rad[63:62]};
      trial   = {1'b0, s.root, 2'b01};
      o.rad   = {s.rad[61:0], 2'b00};
      if (shifted >= trial) begin
         o.rem  = shifted - trial;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = shifted;
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   function automatic sqrt_type sqrt_stage(input sqrt_type s);
      sqrt_type o;
      o = s;
      for (int j = 0; j < StepsPerStage; j++) begin
         o = sqrt_step(o);
      end
      return o;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [39:0] x);
      logic [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/particle_drag_gravity_step_top.sv
// ---------------------------------------------------------------------------
// Particle drag and gravity step
// Pipelined explicit Euler integrator with speed-proportional drag.
// ---------------------------------------------------------------------------
// A particle request is taken at every clock edge where start is high; busy
// is always low, so one particle per cycle is sustained indefinitely. Each
// result appears on the rsp_ ports for one cycle with rsp_strobe high, in
// request order. The receiver has no way to stall, so results must be
// consumed as they appear. The depth is set by the integer square root for
// the speed: 32 digit steps, two per stage, over 16 register stages.
// Expired particles run down the same pipeline and leave unchanged with
// rsp_expired set. Write the csr_ registers only while no particle is in
// flight; gravity reaches requests through one more register, dg_ff.
// There is no memory and no clearing pass after reset.
`timescale 1ns / 1ps

module particle_drag_gravity_step_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_pos_x,
   input  logic signed [31:0]          req_pos_y,
   input  logic signed [31:0]          req_pos_z,
   input  logic signed [31:0]          req_vel_x,
   input  logic signed [31:0]          req_vel_y,
   input  logic signed [31:0]          req_vel_z,
   input  logic [31:0]                 req_expiry_time,
   input  logic [31:0]                 req_current_time,
   input  logic                        req_last_in,
   // result channel
   output logic                        rsp_strobe,
   output logic signed [31:0]          rsp_new_pos_x,
   output logic signed [31:0]          rsp_new_pos_y,
   output logic signed [31:0]          rsp_new_pos_z,
   output logic signed [31:0]          rsp_new_vel_x,
   output logic signed [31:0]          rsp_new_vel_y,
   output logic signed [31:0]          rsp_new_vel_z,
   output logic                        rsp_expired,
   output logic                        rsp_last_out,
   // configuration port
   input  logic                        csr_write_enable,
   input  pdgs_pkg::csr_index_type     csr_index,
   input  logic [23:0]                 csr_write_data
);

   import pdgs_pkg::*;

   `include "particle_drag_gravity_step_top_assert.svh"

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [31:0]      expiry;
      logic [31:0]      now;
      logic             last;
   } request_type;

   typedef struct packed {
      particle_type     part;
      logic [2:0][63:0] sq;
      logic [2:0][39:0] dpos;
   } square_type;

   typedef struct packed {
      particle_type part;
      logic [63:0]  sumsq;
   } sum_type;

   typedef struct packed {
      particle_type part;
      sqrt_type     sq;
   } root_stage_type;

   typedef struct packed {
      particle_type part;
      logic [54:0]  prod;
   } speed_drag_type;

   typedef struct packed {
      particle_type part;
      logic [55:0]  prod;
   } friction_type;

   typedef struct packed {
      particle_type part;
      logic [16:0]  scale;
   } scale_stage_type;

   typedef struct packed {
      particle_type     part;
      logic [2:0][49:0] prod;
   } vel_prod_type;

   // configuration
   logic [22:0]        step_time_ff;
   logic [22:0]        drag_coef_ff;
   logic signed [23:0] gravity_ff;
   logic [31:0]        dg_ff, dg_in;
   logic [47:0]        grav_prod;

   // pipeline registers and valid bits
   request_type                         req_ff, req_in;
   square_type                          square_ff, square_in;
   sum_type                             sum_ff, sum_in;
   root_stage_type [SqrtStages-1:0]     root_ff, root_in;
   speed_drag_type                      sd_ff, sd_in;
   friction_type                        fric_ff, fric_in;
   scale_stage_type                     scale_ff, scale_in;
   vel_prod_type                        vprod_ff, vprod_in;
   particle_type                        out_ff, out_in;

   logic                  req_valid_ff, req_valid_in;
   logic                  square_valid_ff, square_valid_in;
   logic                  sum_valid_ff, sum_valid_in;
   logic [SqrtStages-1:0] root_valid_ff, root_valid_in;
   logic                  sd_valid_ff, sd_valid_in;
   logic                  fric_valid_ff, fric_valid_in;
   logic                  scale_valid_ff, scale_valid_in;
   logic                  vprod_valid_ff, vprod_valid_in;
   logic                  out_valid_ff, out_valid_in;

   // intermediates
   logic [2:0][31:0] mag;
   logic [2:0][55:0] dpos_prod;
   logic [2:0][31:0] vel_scaled;
   sqrt_type         root_seed;
   logic [31:0]      speed;
   logic [38:0]      t_full;
   logic [32:0]      t_sat;
   logic [39:0]      fric_full;

   // the pipeline never stalls: take a request in every cycle
   assign busy = 1'b0;

   // gravity times step, refreshed every cycle from the configuration
   assign grav_prod = $signed({{24{gravity_ff[23]}}, gravity_ff})
                    * $signed({25'b0, step_time_ff});
   assign dg_in     = grav_prod[47:16];

   always_comb begin
      // stage 1: register the request
      req_valid_in = start;
      req_in.pos   = {req_pos_z, req_pos_y, req_pos_x};
      req_in.vel   = {req_vel_z, req_vel_y, req_vel_x};
      req_in.expiry = req_expiry_time;
      req_in.now    = req_current_time;
      req_in.last   = req_last_in;

      // stage 2: squares, position deltas, expiry test
      square_valid_in        = req_valid_ff;
      square_in.part.pos     = req_ff.pos;
      square_in.part.vel     = req_ff.vel;
      square_in.part.expired = req_ff.now > req_ff.expiry;
      square_in.part.last    = req_ff.last;
      for (int i = 0; i < 3; i++) begin
         mag[i] = req_ff.vel[i][31] ? (~req_ff.vel[i] + 32'd1) : req_ff.vel[i];
         square_in.sq[i] = {32'b0, mag[i]} * {32'b0, mag[i]};
         dpos_prod[i]    = $signed({{24{req_ff.vel[i][31]}}, req_ff.vel[i]})
                         * $signed({33'b0, step_time_ff});
         square_in.dpos[i] = dpos_prod[i][55:16];
      end

      // stage 3: sum of squares, saturated new position
      sum_valid_in = square_valid_ff;
      sum_in.part  = square_ff.part;
      sum_in.sumsq = square_ff.sq[0] + square_ff.sq[1] + square_ff.sq[2];
      for (int i = 0; i < 3; i++) begin
         if (!square_ff.part.expired) begin
            sum_in.part.pos[i] = sat32($signed({{8{square_ff.part.pos[i][31]}},
                                                square_ff.part.pos[i]})
                                     + $signed(square_ff.dpos[i]));
         end
      end

      // root stages: advance two digits of the square root each
      root_seed.rad  = sum_ff.sumsq;
      root_seed.rem  = 35'd0;
      root_seed.root = 32'd0;
      root_valid_in[0] = sum_valid_ff;
      root_in[0].part  = sum_ff.part;
      root_in[0].sq    = sqrt_stage(root_seed);
      for (int k = 1; k < SqrtStages; k++) begin
         root_valid_in[k] = root_valid_ff[k-1];
         root_in[k].part  = root_ff[k-1].part;
         root_in[k].sq    = sqrt_stage(root_ff[k-1].sq);
      end

      // speed times drag coefficient
      speed       = root_ff[SqrtStages-1].sq.root;
      sd_valid_in = root_valid_ff[SqrtStages-1];
      sd_in.part  = root_ff[SqrtStages-1].part;
      sd_in.prod  = {23'b0, speed} * {32'b0, drag_coef_ff};

      // times step; any t of 2^32 or more already saturates the friction
      t_full        = sd_ff.prod[54:16];
      t_sat         = (|t_full[38:32]) ? 33'h1_0000_0000 : {1'b0, t_full[31:0]};
      fric_valid_in = sd_valid_ff;
      fric_in.part  = sd_ff.part;
      fric_in.prod  = {23'b0, t_sat} * {33'b0, step_time_ff};

      // clamp friction to one, form the velocity scale
      fric_full      = fric_ff.prod[55:16];
      scale_valid_in = fric_valid_ff;
      scale_in.part  = fric_ff.part;
      scale_in.scale = (fric_full >= {23'b0, QOne}) ? 17'd0 : (QOne - fric_full[16:0]);

      // scale each velocity component
      vprod_valid_in = scale_valid_ff;
      vprod_in.part  = scale_ff.part;
      for (int i = 0; i < 3; i++) begin
         vprod_in.prod[i] = $signed({{18{scale_ff.part.vel[i][31]}}, scale_ff.part.vel[i]})
                          * $signed({33'b0, scale_ff.scale});
      end

      // add gravity to y, saturate, drop the update for expired particles
      out_valid_in = vprod_valid_ff;
      out_in       = vprod_ff.part;
      for (int i = 0; i < 3; i++) begin
         vel_scaled[i] = vprod_ff.prod[i][47:16];
      end
      if (!vprod_ff.part.expired) begin
         out_in.vel[0] = vel_scaled[0];
         out_in.vel[1] = sat32($signed({{8{vel_scaled[1][31]}}, vel_scaled[1]})
                             + $signed({{8{dg_ff[31]}}, dg_ff}));
         out_in.vel[2] = vel_scaled[2];
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff    <= StepTimeReset;
         drag_coef_ff    <= DragCoefReset;
         gravity_ff      <= GravityReset;
         req_valid_ff    <= 1'b0;
         square_valid_ff <= 1'b0;
         sum_valid_ff    <= 1'b0;
         root_valid_ff   <= '0;
         sd_valid_ff     <= 1'b0;
         fric_valid_ff   <= 1'b0;
         scale_valid_ff  <= 1'b0;
         vprod_valid_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               RegStepTime: step_time_ff <= csr_write_data[22:0];
               RegDragCoef: drag_coef_ff <= csr_write_data[22:0];
               RegGravity:  gravity_ff   <= $signed(csr_write_data);
               default: begin
               end
            endcase
         end
         req_valid_ff    <= req_valid_in;
         square_valid_ff <= square_valid_in;
         sum_valid_ff    <= sum_valid_in;
         root_valid_ff   <= root_valid_in;
         sd_valid_ff     <= sd_valid_in;
         fric_valid_ff   <= fric_valid_in;
         scale_valid_ff  <= scale_valid_in;
         vprod_valid_ff  <= vprod_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload advances every cycle alongside its valid bit
   always_ff @(posedge clock) begin
      dg_ff     <= dg_in;
      req_ff    <= req_in;
      square_ff <= square_in;
      sum_ff    <= sum_in;
      root_ff   <= root_in;
      sd_ff     <= sd_in;
      fric_ff   <= fric_in;
      scale_ff  <= scale_in;
      vprod_ff  <= vprod_in;
      out_ff    <= out_in;
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_new_pos_x = out_ff.pos[0];
   assign rsp_new_pos_y = out_ff.pos[1];
   assign rsp_new_pos_z = out_ff.pos[2];
   assign rsp_new_vel_x = out_ff.vel[0];
   assign rsp_new_vel_y = out_ff.vel[1];
   assign rsp_new_vel_z = out_ff.vel[2];
   assign rsp_expired   = out_ff.expired;
   assign rsp_last_out  = out_ff.last;

   // every request returns a result with rsp_strobe high
   `PDGS_ASSERT_DELAY(a_request_returns, clock, reset, start && !busy, Latency, rsp_strobe)
   // no result without a matching earlier request
   `PDGS_ASSERT_IMPL(a_no_orphan_result, clock, reset, rsp_strobe, $past(start && !busy, Latency))
   // an expired particle leaves with its request's x position and y velocity
   `PDGS_ASSERT_IMPL(a_expired_passthrough, clock, reset, rsp_strobe && rsp_expired, (rsp_new_pos_x == $past(req_pos_x, Latency)) && (rsp_new_vel_y == $past(req_vel_y, Latency)))

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Particle drag and gravity step testbench
// Drives particle requests through the integrator and checks every result
// against a hand-written value or a cycle-free Euler, drag and gravity predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import pdgs_pkg::*;

   // index 3 decodes to no register; writes to it must change nothing
   localparam csr_index_type RegUnused = 2'd3;

   localparam int MaxGap      = 8;
   localparam int RandomItems = 600;
   localparam int ResetCycles = 12;
   // cycles without any request, result or register write before giving up
   localparam int StallLimit  = 20 * Latency;
   localparam int MaxReports  = 40;

   localparam logic [31:0] QMax     = 32'h7FFF_FFFF;
   localparam logic [31:0] QMin     = 32'h8000_0000;
   // one reset-valued step of gravity from rest: floor(-642253 * 1092 / 2^16)
   localparam logic [31:0] RestVelY = -32'sd10702;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        expiry_time;
      logic [31:0]        current_time;
      logic               last_in;
   } particle_req_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               expired;
      logic               last_out;
   } particle_upd_type;

   typedef enum logic {RowParticle, RowWrite} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      csr_index_type    index;
      logic [23:0]      data;
      particle_req_type req;
      bit               typed;
      particle_upd_type upd;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [31:0]   req_pos_x;
   logic signed [31:0]   req_pos_y;
   logic signed [31:0]   req_pos_z;
   logic signed [31:0]   req_vel_x;
   logic signed [31:0]   req_vel_y;
   logic signed [31:0]   req_vel_z;
   logic [31:0]          req_expiry_time;
   logic [31:0]          req_current_time;
   logic                 req_last_in;
   logic                 rsp_strobe;
   logic signed [31:0]   rsp_new_pos_x;
   logic signed [31:0]   rsp_new_pos_y;
   logic signed [31:0]   rsp_new_pos_z;
   logic signed [31:0]   rsp_new_vel_x;
   logic signed [31:0]   rsp_new_vel_y;
   logic signed [31:0]   rsp_new_vel_z;
   logic                 rsp_expired;
   logic                 rsp_last_out;
   logic                 csr_write_enable;
   csr_index_type        csr_index;
   logic [23:0]          csr_write_data;

   // shadow copy of the three registers as the block should hold them
   logic [22:0]          step_time_q;
   logic [22:0]          drag_coef_q;
   logic signed [23:0]   gravity_q;

   particle_upd_type     pending_updates[$];
   stim_row_type         directed_rows[$];
   particle_upd_type     got_upd;
   particle_upd_type     want_upd;

   int                   error_count   = 0;
   int                   checked_count = 0;
   int                   sent_count    = 0;
   int                   expired_count = 0;
   int                   write_count   = 0;
   int                   quiet_cycles  = 0;

   particle_drag_gravity_step_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_vel_x        (req_vel_x),
      .req_vel_y        (req_vel_y),
      .req_vel_z        (req_vel_z),
      .req_expiry_time  (req_expiry_time),
      .req_current_time (req_current_time),
      .req_last_in      (req_last_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_new_pos_x    (rsp_new_pos_x),
      .rsp_new_pos_y    (rsp_new_pos_y),
      .rsp_new_pos_z    (rsp_new_pos_z),
      .rsp_new_vel_x    (rsp_new_vel_x),
      .rsp_new_vel_y    (rsp_new_vel_y),
      .rsp_new_vel_z    (rsp_new_vel_z),
      .rsp_expired      (rsp_expired),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Saturate a wide signed value to the Q16.16 range.
   function automatic logic [31:0] clamp_q16(input longint x);
      if (x > 64'sd2147483647) begin
         return QMax;
      end
      if (x < -64'sd2147483648) begin
         return QMin;
      end
      return x[31:0];
   endfunction

   // Floor of the square root, one result bit per probe position.
   function automatic longint unsigned root_u64(input longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      longint unsigned rest;
      res   = 0;
      rest  = n;
      probe = 64'd1 << 62;
      while (probe > rest) begin
         probe = probe >> 2;
      end
      while (probe != 0) begin
         if (rest >= res + probe) begin
            rest = rest - (res + probe);
            res  = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // One Euler step with drag and gravity under the shadow registers.
   function automatic particle_upd_type integrate_particle(input particle_req_type p);
      longint           pos [3];
      longint           vel [3];
      longint           st;
      longint           dc;
      longint           gv;
      longint           scale;
      longint           dg;
      longint unsigned  mag;
      longint unsigned  sumsq;
      longint unsigned  speed;
      longint unsigned  t;
      longint unsigned  fr;
      particle_upd_type u;
      int               i;
      u.last_out = p.last_in;
      if (p.current_time > p.expiry_time) begin
         // dead particle: pass position and velocity through untouched
         u.pos_x   = p.pos_x;
         u.pos_y   = p.pos_y;
         u.pos_z   = p.pos_z;
         u.vel_x   = p.vel_x;
         u.vel_y   = p.vel_y;
         u.vel_z   = p.vel_z;
         u.expired = 1'b1;
         return u;
      end
      pos[0] = p.pos_x;
      pos[1] = p.pos_y;
      pos[2] = p.pos_z;
      vel[0] = p.vel_x;
      vel[1] = p.vel_y;
      vel[2] = p.vel_z;
      st     = step_time_q;
      dc     = drag_coef_q;
      gv     = gravity_q;
      sumsq  = 0;
      for (i = 0; i < 3; i++) begin
         mag    = (vel[i] < 0) ? -vel[i] : vel[i];
         sumsq  = sumsq + mag * mag;
         // advance with the old velocity, floor of the product
         pos[i] = pos[i] + ((vel[i] * st) >>> 16);
      end
      speed = root_u64(sumsq);
      t     = (speed * dc) >> 16;
      fr    = (t * st) >> 16;
      if (fr > 65536) begin
         fr = 65536;
      end
      scale = 65536 - fr;
      for (i = 0; i < 3; i++) begin
         vel[i] = (vel[i] * scale) >>> 16;
      end
      dg     = (gv * st) >>> 16;
      vel[1] = vel[1] + dg;
      u.pos_x   = clamp_q16(pos[0]);
      u.pos_y   = clamp_q16(pos[1]);
      u.pos_z   = clamp_q16(pos[2]);
      u.vel_x   = clamp_q16(vel[0]);
      u.vel_y   = clamp_q16(vel[1]);
      u.vel_z   = clamp_q16(vel[2]);
      u.expired = 1'b0;
      return u;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic particle_req_type make_req(
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
      input logic [31:0] expiry, input logic [31:0] now, input logic last);
      particle_req_type p;
      p.pos_x        = px;
      p.pos_y        = py;
      p.pos_z        = pz;
      p.vel_x        = vx;
      p.vel_y        = vy;
      p.vel_z        = vz;
      p.expiry_time  = expiry;
      p.current_time = now;
      p.last_in      = last;
      return p;
   endfunction

   function automatic particle_upd_type make_upd(
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
      input logic dead, input logic last);
      particle_upd_type u;
      u.pos_x    = px;
      u.pos_y    = py;
      u.pos_z    = pz;
      u.vel_x    = vx;
      u.vel_y    = vy;
      u.vel_z    = vz;
      u.expired  = dead;
      u.last_out = last;
      return u;
   endfunction

   // Particle row checked against the predictor.
   function automatic void add_particle(input particle_req_type p);
      stim_row_type row;
      row.kind  = RowParticle;
      row.index = RegStepTime;
      row.data  = '0;
      row.req   = p;
      row.typed = 1'b0;
      row.upd   = make_upd(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      directed_rows.push_back(row);
   endfunction

   // Particle row whose result is written out by hand.
   function automatic void add_checked(input particle_req_type p, input particle_upd_type u);
      stim_row_type row;
      row.kind  = RowParticle;
      row.index = RegStepTime;
      row.data  = '0;
      row.req   = p;
      row.typed = 1'b1;
      row.upd   = u;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input csr_index_type idx, input logic [23:0] data);
      stim_row_type row;
      row.kind  = RowWrite;
      row.index = idx;
      row.data  = data;
      row.req   = make_req(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      row.typed = 1'b0;
      row.upd   = make_upd(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      directed_rows.push_back(row);
   endfunction

   // Q16.16 value from one of four magnitude classes.
   function automatic logic [31:0] random_q16(input int unsigned cls);
      logic [31:0] r;
      r = $urandom();
      case (cls)
         0: begin
            return r;
         end
         1: begin
            // up to 16 units either way
            return 32'($urandom_range(32'd2097152, 0) - 32'd1048576);
         end
         2: begin
            return {{6{r[25]}}, r[25:0]};
         end
         default: begin
            case ($urandom_range(4, 0))
               0:       return QMax;
               1:       return QMin;
               2:       return 32'd0;
               3:       return 32'hFFFF_FFFF;
               default: return 32'd1;
            endcase
         end
      endcase
   endfunction

   function automatic particle_req_type random_particle();
      particle_req_type p;
      int unsigned      vcls;
      int unsigned      pcls;
      int unsigned      pick;
      bit               mixed;
      logic [31:0]      now;
      vcls    = $urandom_range(3, 0);
      pcls    = $urandom_range(3, 0);
      mixed   = ($urandom_range(9, 0) == 0);
      p.pos_x = random_q16(pcls);
      p.pos_y = random_q16(pcls);
      p.pos_z = random_q16(pcls);
      p.vel_x = random_q16(mixed ? $urandom_range(3, 0) : vcls);
      p.vel_y = random_q16(mixed ? $urandom_range(3, 0) : vcls);
      p.vel_z = random_q16(mixed ? $urandom_range(3, 0) : vcls);
      now     = $urandom();
      pick    = $urandom_range(9, 0);
      if (pick < 3) begin
         // expired: the clock is strictly past expiry
         if (now == 0) begin
            now = 32'd1;
         end
         p.expiry_time = $urandom_range(now - 32'd1, 0);
      end else if (pick == 3) begin
         p.expiry_time = now;
      end else begin
         p.expiry_time = now + $urandom_range(~now, 0);
      end
      p.current_time = now;
      p.last_in      = $urandom_range(1, 0);
      return p;
   endfunction

   // Step time or drag value; bit 23 is random since the block drops it.
   function automatic logic [23:0] random_rate_reg(input logic [22:0] rst_val);
      logic top;
      top = $urandom_range(1, 0);
      case ($urandom_range(5, 0))
         0:       return {top, 23'd0};
         1:       return {top, 23'h7F_FFFF};
         2:       return {top, 23'h40_0000};
         3:       return {top, 23'($urandom_range(131072, 0))};
         4:       return {top, rst_val};
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [23:0] random_gravity();
      case ($urandom_range(6, 0))
         0:       return 24'h7F_FFFF;
         1:       return 24'h80_0000;
         2:       return 24'h40_0000;
         3:       return 24'hC0_0000;
         4:       return GravityReset;
         5:       return 24'h00_0000;
         default: return 24'($urandom());
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks, called at a rising edge and returning at one
   // -------------------------------------------------------------------------

   // Hold start low through the gap, present the request until it is taken,
   // then queue the result it must produce.
   task automatic send_particle(input particle_req_type p, input bit typed,
                                input particle_upd_type u, input int unsigned gap);
      particle_upd_type want;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_pos_x        <= p.pos_x;
      req_pos_y        <= p.pos_y;
      req_pos_z        <= p.pos_z;
      req_vel_x        <= p.vel_x;
      req_vel_y        <= p.vel_y;
      req_vel_z        <= p.vel_z;
      req_expiry_time  <= p.expiry_time;
      req_current_time <= p.current_time;
      req_last_in      <= p.last_in;
      do begin
         @(posedge clock);
      end while (busy);
      if (typed) begin
         want = u;
      end else begin
         want = integrate_particle(p);
      end
      pending_updates.push_back(want);
      sent_count++;
      if (want.expired) begin
         expired_count++;
      end
   endtask

   // Stop sending and wait until every queued result has come back.
   task automatic drain_updates();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_updates.size() != 0);
   endtask

   // One register write, then a pause with the enable low so it is in effect
   // for the next request.
   task automatic write_register(input csr_index_type idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         RegStepTime: step_time_q = data[22:0];
         RegDragCoef: drag_coef_q = data[22:0];
         RegGravity:  gravity_q   = data;
         default:     ;
      endcase
      write_count++;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result monitor: compare each strobed result with the oldest expectation
   // -------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (error_count < MaxReports) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         // any handshake, result or write counts as progress for the watchdog
         if ((start && !busy) || rsp_strobe || csr_write_enable) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_strobe) begin
            got_upd.pos_x    = rsp_new_pos_x;
            got_upd.pos_y    = rsp_new_pos_y;
            got_upd.pos_z    = rsp_new_pos_z;
            got_upd.vel_x    = rsp_new_vel_x;
            got_upd.vel_y    = rsp_new_vel_y;
            got_upd.vel_z    = rsp_new_vel_z;
            got_upd.expired  = rsp_expired;
            got_upd.last_out = rsp_last_out;
            if (pending_updates.size() == 0) begin
               if (error_count < MaxReports) begin
                  $display("%0t: result with no request outstanding", $time);
               end
               error_count++;
            end else begin
               want_upd = pending_updates.pop_front();
               check_field("new_pos_x", want_upd.pos_x, got_upd.pos_x);
               check_field("new_pos_y", want_upd.pos_y, got_upd.pos_y);
               check_field("new_pos_z", want_upd.pos_z, got_upd.pos_z);
               check_field("new_vel_x", want_upd.vel_x, got_upd.vel_x);
               check_field("new_vel_y", want_upd.vel_y, got_upd.vel_y);
               check_field("new_vel_z", want_upd.vel_z, got_upd.vel_z);
               check_field("expired", want_upd.expired, got_upd.expired);
               check_field("last_out", want_upd.last_out, got_upd.last_out);
               checked_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin : watchdog
      do begin
         @(posedge clock);
      end while (quiet_cycles < StallLimit);
      $display("%0t: timeout, no activity for %0d cycles", $time, StallLimit);
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   initial begin : stimulus
      stim_row_type     row;
      particle_upd_type no_upd;
      int               k;
      int               random_sent;
      int               phase_count;
      int unsigned      batch;
      bit               burst;

      // drive every input to a known value before the first edge
      reset            <= 1'b1;
      start            <= 1'b0;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_pos_z        <= '0;
      req_vel_x        <= '0;
      req_vel_y        <= '0;
      req_vel_z        <= '0;
      req_expiry_time  <= '0;
      req_current_time <= '0;
      req_last_in      <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= RegStepTime;
      csr_write_data   <= '0;
      step_time_q      = StepTimeReset;
      drag_coef_q      = DragCoefReset;
      gravity_q        = GravityReset;
      no_upd           = make_upd(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      phase_count      = 0;

      // Directed rows, first under the reset register values.
      // at rest, both times zero: equal times are live, only gravity acts
      add_checked(make_req(0, 0, 0, 0, 0, 0, 0, 0, 1'b0),
                  make_upd(0, 0, 0, 0, RestVelY, 0, 1'b0, 1'b0));
      // one tick past expiry: everything passes through
      add_checked(make_req(QMax, QMin, 32'h1234_5678, QMin, QMax, 32'hFFFF_FFFF, 0, 1, 1'b1),
                  make_upd(QMax, QMin, 32'h1234_5678, QMin, QMax, 32'hFFFF_FFFF, 1'b1, 1'b1));
      // expiry at the top of the time range
      add_checked(make_req(32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_FFFF, 32'h0001_0000,
                           32'hFFFF_0000, QMax, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0),
                  make_upd(32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_FFFF, 32'h0001_0000,
                           32'hFFFF_0000, QMax, 1'b1, 1'b0));
      // equal times at the top of the range are still live
      add_checked(make_req(QMax, QMin, QMax, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
                  make_upd(QMax, QMin, QMax, 0, RestVelY, 0, 1'b0, 1'b1));
      // full-scale velocities: friction clamps at one
      add_particle(make_req(0, 0, 0, QMax, QMin, QMax, 32'h0010_0000, 0, 1'b0));
      add_particle(make_req(32'h1000_0000, 32'hF000_0000, 0, QMin, QMin, QMin, 5, 5, 1'b1));
      // modest speed: friction stays below one
      add_particle(make_req(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                            32'h0002_0000, 32'h0001_0000, 1'b0));
      // smallest velocities: floor rounding on negative products
      add_particle(make_req(5, -5, 0, 32'hFFFF_FFFF, 1, 0, 9, 3, 1'b1));
      // longest step, no drag, strongest upward gravity
      add_write(RegStepTime, 24'h7F_FFFF);
      add_write(RegDragCoef, 24'h00_0000);
      add_write(RegGravity, 24'h7F_FFFF);
      // positions saturate both ways, y velocity saturates high
      add_particle(make_req(QMax, 0, QMin, QMax, QMax, QMin, 0, 0, 1'b1));
      add_particle(make_req(QMin, QMax, 0, QMin, 0, 32'h4000_0000, 1, 0, 1'b0));
      // strongest downward gravity: y velocity saturates low
      add_write(RegGravity, 24'h80_0000);
      add_particle(make_req(0, 0, 0, 0, QMin, 0, 0, 0, 1'b0));
      // write to the unused index: nothing may change
      add_write(RegUnused, 24'h12_3456);
      add_particle(make_req(0, 0, 0, 0, QMin, 0, 0, 0, 1'b1));
      // bit 23 is dropped, so this is a zero step; drag goes to its maximum
      add_write(RegStepTime, 24'h80_0000);
      add_write(RegDragCoef, 24'hFF_FFFF);
      // zero step: a live particle comes out unchanged
      add_checked(make_req(32'h0BAD_F00D, QMin, 7, QMax, QMin, 32'hDEAD_BEEF, 9, 9, 1'b1),
                  make_upd(32'h0BAD_F00D, QMin, 7, QMax, QMin, 32'hDEAD_BEEF, 1'b0, 1'b1));
      // one-second step with huge drag: friction far over one, then tiny
      add_write(RegStepTime, 24'h01_0000);
      add_particle(make_req(0, 0, 0, 32'h0001_0000, 0, 0, 1, 0, 1'b0));
      add_particle(make_req(0, 0, 0, 0, 0, 1, 1, 0, 1'b1));

      // hold reset, then release it once
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed rows; drain before each write so the block is idle
      for (k = 0; k < directed_rows.size(); k++) begin
         row = directed_rows[k];
         if (row.kind == RowWrite) begin
            drain_updates();
            write_register(row.index, row.data);
         end else begin
            send_particle(row.req, row.typed, row.upd, $urandom_range(MaxGap, 0));
         end
      end

      // Random phases: drain (the sender pauses until all results are back),
      // pick a fresh register setting, then stream a batch of particles.
      random_sent = 0;
      while (random_sent < RandomItems) begin
         drain_updates();
         write_register(RegStepTime, random_rate_reg(StepTimeReset));
         write_register(RegDragCoef, random_rate_reg(DragCoefReset));
         write_register(RegGravity, random_gravity());
         if ($urandom_range(4, 0) == 0) begin
            write_register(RegUnused, 24'($urandom()));
         end
         // some batches run back to back, the rest take random gaps between requests
         burst = ($urandom_range(3, 0) == 0);
         batch = $urandom_range(80, 20);
         repeat (batch) begin
            send_particle(random_particle(), 1'b0, no_upd,
                          burst ? 0 : $urandom_range(MaxGap, 0));
            random_sent++;
         end
         phase_count++;
      end

      // drain, then watch a little longer for stray results
      drain_updates();
      repeat (Latency + 4) @(posedge clock);

      $display("Sent %0d particles (%0d expired) over %0d random register settings",
               sent_count, expired_count, phase_count);
      $display("Made %0d register writes and checked %0d results field by field",
               write_count, checked_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pdgs_pkg.sv
rtl/particle_drag_gravity_step_top.sv
tb/tb.sv
